// File: rtl/tbgd_pkg.sv
// ----------------------------------------------------------------------------
// tbgd_pkg
// Widths, types and codes shared by the two-body gravity derivative block.
// ----------------------------------------------------------------------------
package tbgd_pkg;

    localparam int POS_W   = 24;
    localparam int VEL_W   = 32;
    localparam int RATE_W  = 32;
    localparam int ACC_W   = 48;
    localparam int MU_W    = 48;
    localparam int MINR_W  = 41;
    localparam int MAG_W   = 24;
    localparam int HALF_W  = 24;
    localparam int PP_W    = 48;
    localparam int S_W     = 48;
    localparam int RAD_W   = 80;
    localparam int ROOT_W  = 40;
    localparam int REM_W   = 41;
    localparam int CHUNK_W = 20;
    localparam int SQ_W    = 80;
    localparam int PROD_W  = 60;
    localparam int DEN_W   = 120;
    localparam int NUM_W   = 135;
    localparam int PROD_SH = 64;
    localparam int Q_W     = 49;
    localparam int DSH_W   = DEN_W + Q_W - 1;
    localparam int IN_W    = 168;
    localparam int OUT_W   = 248;
    localparam int ST_W    = 2;

    localparam logic [ACC_W-1:0] ACC_MAX_POS = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MAX_NEG = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic REG_GRAV_PARAM = 1'b0;
    localparam logic REG_MIN_RADIUS = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_CLOSE = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0][RATE_W-1:0] rate;
        logic [2:0]             neg;
        logic [2:0][NUM_W-1:0]  num;
        logic                   close;
    } side_t;

    typedef struct packed {
        logic [2:0][RATE_W-1:0] rate;
        logic [2:0]             neg;
        logic                   close;
    } tail_t;

endpackage

// File: rtl/tbgd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tbgd_sqrt_cell
// One digit step of the radius square root, producing one root bit.
// ----------------------------------------------------------------------------
module tbgd_sqrt_cell import tbgd_pkg::*; (
    input  logic              aclk,
    input  logic              adv,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [RAD_W-1:0]  rad_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W:0]    rem_sh, trial, diff;
    logic              fits;

    always_comb begin
        rem_sh    = {rem_in[REM_W-2:0], rad_in[RAD_W-1 -: 2]};
        trial     = {root_in, 2'b01};
        diff      = rem_sh - trial;
        fits      = rem_sh >= trial;
        rem_next  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_next = {root_in[ROOT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// File: rtl/tbgd_div_cell.sv
// ----------------------------------------------------------------------------
// tbgd_div_cell
// One restoring division step for all three axes against a shared divisor.
// ----------------------------------------------------------------------------
module tbgd_div_cell import tbgd_pkg::*; (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic [DSH_W-1:0]      dsh_in,
    input  logic [2:0][NUM_W-1:0] rem_in,
    input  logic [2:0][Q_W-1:0]   q_in,
    output logic [DSH_W-1:0]      dsh_out,
    output logic [2:0][NUM_W-1:0] rem_out,
    output logic [2:0][Q_W-1:0]   q_out
);

    logic [DSH_W-1:0]      dsh_reg;
    logic [2:0][NUM_W-1:0] rem_reg, rem_next;
    logic [2:0][Q_W-1:0]   q_reg, q_next;
    logic [2:0]            ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ge[i]       = {{(DSH_W-NUM_W){1'b0}}, rem_in[i]} >= dsh_in;
            rem_next[i] = ge[i] ? rem_in[i] - dsh_in[NUM_W-1:0] : rem_in[i];
            q_next[i]   = {q_in[i][Q_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dsh_reg <= {1'b0, dsh_in[DSH_W-1:1]};
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign dsh_out = dsh_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

// File: rtl/two_body_gravity_derivative.sv
// ----------------------------------------------------------------------------
// two_body_gravity_derivative
// Two-body equations of motion: rates pass through, accelerations are
// -mu*p/|r|^3 from a square root chain and a three-axis divider chain.
// ----------------------------------------------------------------------------
// Throughput is one transaction per cycle when the output is not stalled,
// set by the 40-cell square root and 49-cell divider chains, which advance
// together. The pipeline holds while a result waits on m_tready.
// Reset clears the configuration registers and every valid flag.
module two_body_gravity_derivative import tbgd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, status, zero pad
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [MU_W-1:0]   cfg_wr_data
);

    localparam int NSQ = ROOT_W;
    localparam int NDV = Q_W;

    logic [MU_W-1:0]   grav_param_reg;
    logic [MINR_W-1:0] min_radius_reg;
    logic              adv;
    logic              m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_param_reg <= '0;
            min_radius_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GRAV_PARAM: grav_param_reg <= cfg_wr_data;
                REG_MIN_RADIUS: min_radius_reg <= cfg_wr_data[MINR_W-1:0];
                default:        grav_param_reg <= grav_param_reg;
            endcase
        end
    end

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Input stage.
    logic                   v0_reg;
    logic [2:0][MAG_W-1:0]  mag0_reg;
    logic [2:0]             neg0_reg;
    logic [2:0][RATE_W-1:0] rate0_reg;
    logic [2:0][POS_W-1:0]  pos_in;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_in[i] = s_tdata[i*POS_W +: POS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                neg0_reg[i]  <= pos_in[i][POS_W-1];
                mag0_reg[i]  <= pos_in[i][POS_W-1] ? MAG_W'(-pos_in[i]) : pos_in[i];
                rate0_reg[i] <= s_tdata[3*POS_W + i*VEL_W +: VEL_W];
            end
        end
    end

    // Products stage.
    logic                   v1_reg;
    logic [2:0][PP_W-1:0]   sq1_reg, pl1_reg, ph1_reg;
    logic [2:0]             neg1_reg;
    logic [2:0][RATE_W-1:0] rate1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sq1_reg[i] <= mag0_reg[i] * mag0_reg[i];
                pl1_reg[i] <= grav_param_reg[HALF_W-1:0] * mag0_reg[i];
                ph1_reg[i] <= grav_param_reg[MU_W-1:HALF_W] * mag0_reg[i];
            end
            neg1_reg  <= neg0_reg;
            rate1_reg <= rate0_reg;
        end
    end

    // Sum stage.
    logic                   v2_reg;
    logic [S_W-1:0]         s2_reg;
    side_t                  side2_reg;
    logic [PP_W+HALF_W-1:0] nsum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nsum[i] = {ph1_reg[i], {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pl1_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            for (int i = 0; i < 3; i++) begin
                side2_reg.num[i] <= {nsum[i][NUM_W-PROD_SH-1:0], {PROD_SH{1'b0}}};
            end
            side2_reg.rate  <= rate1_reg;
            side2_reg.neg   <= neg1_reg;
            side2_reg.close <= 1'b0;
        end
    end

    // Square root chain.
    logic [RAD_W-1:0]  rad_w  [NSQ+1];
    logic [REM_W-1:0]  srem_w [NSQ+1];
    logic [ROOT_W-1:0] root_w [NSQ+1];
    side_t             sside_reg [NSQ+1];
    logic [NSQ-1:0]    vs_reg;

    assign rad_w[0]  = {s2_reg, {(RAD_W-S_W){1'b0}}};
    assign srem_w[0] = '0;
    assign root_w[0] = '0;

    always_comb begin
        sside_reg[0] = side2_reg;
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        tbgd_sqrt_cell u_cell (
            .aclk     (aclk),
            .adv      (adv),
            .rad_in   (rad_w[k]),
            .rem_in   (srem_w[k]),
            .root_in  (root_w[k]),
            .rad_out  (rad_w[k+1]),
            .rem_out  (srem_w[k+1]),
            .root_out (root_w[k+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                sside_reg[k+1] <= sside_reg[k];
            end
        end
    end

    // Cube of the radius.
    logic [ROOT_W-1:0]      rq1_reg, rq2_reg;
    logic [PROD_W-1:0]      p0_reg, p1_reg;
    logic [SQ_W-1:0]        sq2_reg;
    logic [3:0][PROD_W-1:0] c3_reg;
    logic [DEN_W-1:0]       den4_reg;
    side_t                  e1_reg, e2_reg, e3_reg, e4_reg;
    logic [3:0]             ve_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rq1_reg <= root_w[NSQ];
            p0_reg  <= root_w[NSQ] * root_w[NSQ][CHUNK_W-1:0];
            p1_reg  <= root_w[NSQ] * root_w[NSQ][ROOT_W-1:CHUNK_W];
            e1_reg  <= '{rate:  sside_reg[NSQ].rate,
                         neg:   sside_reg[NSQ].neg,
                         num:   sside_reg[NSQ].num,
                         close: ({1'b0, root_w[NSQ]} <= min_radius_reg)};

            rq2_reg <= rq1_reg;
            sq2_reg <= {{CHUNK_W{1'b0}}, p0_reg} + {p1_reg, {CHUNK_W{1'b0}}};
            e2_reg  <= e1_reg;

            for (int j = 0; j < 4; j++) begin
                c3_reg[j] <= sq2_reg[j*CHUNK_W +: CHUNK_W] * rq2_reg;
            end
            e3_reg <= e2_reg;

            den4_reg <= {{(DEN_W-PROD_W){1'b0}}, c3_reg[0]}
                      + {{(DEN_W-PROD_W-CHUNK_W){1'b0}}, c3_reg[1], {CHUNK_W{1'b0}}}
                      + {{(DEN_W-PROD_W-2*CHUNK_W){1'b0}}, c3_reg[2], {(2*CHUNK_W){1'b0}}}
                      + {c3_reg[3], {(3*CHUNK_W){1'b0}}};
            e4_reg   <= e3_reg;
        end
    end

    // Divider chain.
    logic [DSH_W-1:0]      dsh_w [NDV+1];
    logic [2:0][NUM_W-1:0] drem_w [NDV+1];
    logic [2:0][Q_W-1:0]   q_w [NDV+1];
    tail_t                 tail_reg [NDV+1];
    logic [NDV-1:0]        vd_reg;

    assign dsh_w[0]  = {den4_reg, {(Q_W-1){1'b0}}};
    assign q_w[0]    = '0;
    assign drem_w[0] = e4_reg.num;

    always_comb begin
        tail_reg[0].rate  = e4_reg.rate;
        tail_reg[0].neg   = e4_reg.neg;
        tail_reg[0].close = e4_reg.close;
    end

    for (genvar k = 0; k < NDV; k++) begin : g_div
        tbgd_div_cell u_cell (
            .aclk    (aclk),
            .adv     (adv),
            .dsh_in  (dsh_w[k]),
            .rem_in  (drem_w[k]),
            .q_in    (q_w[k]),
            .dsh_out (dsh_w[k+1]),
            .rem_out (drem_w[k+1]),
            .q_out   (q_w[k+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                tail_reg[k+1] <= tail_reg[k];
            end
        end
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vs_reg <= '0;
            ve_reg <= '0;
            vd_reg <= '0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            vs_reg <= {vs_reg[NSQ-2:0], v2_reg};
            ve_reg <= {ve_reg[2:0], vs_reg[NSQ-1]};
            vd_reg <= {vd_reg[NDV-2:0], ve_reg[3]};
        end
    end

    // Result stage.
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [2:0][ACC_W-1:0]  acc;
    logic [2:0]             sat;
    logic                   res_neg;
    logic [Q_W-1:0]         q;
    logic [ACC_W-1:0]       qmag;
    status_t                st;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q       = q_w[NDV][i];
            res_neg = !tail_reg[NDV].neg[i];
            sat[i]  = q[Q_W-1] || (res_neg ? (q[ACC_W-1] && (|q[ACC_W-2:0]))
                                           : q[ACC_W-1]);
            qmag    = sat[i] ? (res_neg ? ACC_MAX_NEG : ACC_MAX_POS) : q[ACC_W-1:0];
            acc[i]  = tail_reg[NDV].close ? '0 : (res_neg ? -qmag : qmag);
        end
        if (tail_reg[NDV].close) begin
            st = ST_TOO_CLOSE;
        end else if (|sat) begin
            st = ST_SATURATED;
        end else begin
            st = ST_OK;
        end
        m_tdata_next = {{(OUT_W-3*RATE_W-3*ACC_W-ST_W){1'b0}}, st,
                        acc[2], acc[1], acc[0],
                        tail_reg[NDV].rate[2], tail_reg[NDV].rate[1],
                        tail_reg[NDV].rate[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vd_reg[NDV-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/tbgd_checker.sv
// ----------------------------------------------------------------------------
// tbgd_checker
// Port-level checks for the two-body gravity derivative block.
// ----------------------------------------------------------------------------
module tbgd_checker import tbgd_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int ACC_LO = 3 * RATE_W;
    localparam int ST_LO  = 3 * RATE_W + 3 * ACC_W;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[ST_LO +: ST_W] == ST_OK
                  || m_tdata[ST_LO +: ST_W] == ST_TOO_CLOSE
                  || m_tdata[ST_LO +: ST_W] == ST_SATURATED)
        else $error("undefined status code");

    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ST_LO +: ST_W] == ST_TOO_CLOSE
            |-> m_tdata[ACC_LO +: 3*ACC_W] == '0)
        else $error("nonzero acceleration with radius too small");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result waiting");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind two_body_gravity_derivative tbgd_checker u_tbgd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
